FILE: rtl/tdp_pkg.sv
package tdp_pkg;

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_SMALL = 3'd1;
  localparam step_t STEP_BOUND = 3'd2;
  localparam step_t STEP_DINIT = 3'd3;
  localparam step_t STEP_DSTEP = 3'd4;
  localparam step_t STEP_TREM  = 3'd5;
  localparam step_t STEP_NEXT  = 3'd6;
  localparam step_t STEP_EMIT  = 3'd7;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_IN,
    COND_OUT_BUSY,
    COND_LT2,
    COND_SQ_GT,
    COND_BIT_NZ,
    COND_REM_Z
  } cond_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_NEXT
  } op_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    op_t   op;
    logic  set_verdict;
    logic  verdict;
  } ctl_t;

  typedef struct packed {
    logic lt2;
    logic sq_gt;
    logic bit_nz;
    logic rem_z;
  } status_t;

endpackage

FILE: rtl/tdp_rom.sv
module tdp_rom (
  input  tdp_pkg::step_t pc,
  output tdp_pkg::ctl_t  cw
);

  always_comb begin
    unique case (pc)
      tdp_pkg::STEP_IDLE: begin
        cw = '{tdp_pkg::COND_NO_IN, tdp_pkg::STEP_IDLE, tdp_pkg::OP_LOAD, 1'b0, 1'b0};
      end
      tdp_pkg::STEP_SMALL: begin
        cw = '{tdp_pkg::COND_LT2, tdp_pkg::STEP_EMIT, tdp_pkg::OP_NONE, 1'b1, 1'b0};
      end
      tdp_pkg::STEP_BOUND: begin
        cw = '{tdp_pkg::COND_SQ_GT, tdp_pkg::STEP_EMIT, tdp_pkg::OP_NONE, 1'b1, 1'b1};
      end
      tdp_pkg::STEP_DINIT: begin
        cw = '{tdp_pkg::COND_NEVER, tdp_pkg::STEP_IDLE, tdp_pkg::OP_DIV_INIT, 1'b0, 1'b0};
      end
      tdp_pkg::STEP_DSTEP: begin
        cw = '{tdp_pkg::COND_BIT_NZ, tdp_pkg::STEP_DSTEP, tdp_pkg::OP_DIV_STEP, 1'b0, 1'b0};
      end
      tdp_pkg::STEP_TREM: begin
        cw = '{tdp_pkg::COND_REM_Z, tdp_pkg::STEP_EMIT, tdp_pkg::OP_NONE, 1'b1, 1'b0};
      end
      tdp_pkg::STEP_NEXT: begin
        cw = '{tdp_pkg::COND_ALWAYS, tdp_pkg::STEP_BOUND, tdp_pkg::OP_NEXT, 1'b0, 1'b0};
      end
      tdp_pkg::STEP_EMIT: begin
        cw = '{tdp_pkg::COND_OUT_BUSY, tdp_pkg::STEP_EMIT, tdp_pkg::OP_NONE, 1'b0, 1'b0};
      end
    endcase
  end

endmodule

FILE: rtl/tdp_datapath.sv
module tdp_datapath #(
  parameter int WIDTH = 16
) (
  input  logic                clk,
  input  tdp_pkg::op_t        op,
  input  logic [WIDTH-1:0]    in_value,
  output tdp_pkg::status_t    status
);

  localparam int BW = $clog2(WIDTH);

  logic [WIDTH-1:0] value_r, value_nxt;
  logic [WIDTH-1:0] div_r, div_nxt;
  logic [WIDTH:0]   sq_r, sq_nxt;
  logic [WIDTH-1:0] rem_r, rem_nxt;
  logic [BW-1:0]    bit_r, bit_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic [WIDTH-1:0] trial;

  assign shifted = {rem_r, value_r[bit_r]};
  assign diff    = shifted - {1'b0, div_r};
  assign trial   = (shifted >= {1'b0, div_r}) ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];

  always_comb begin
    value_nxt = value_r;
    div_nxt   = div_r;
    sq_nxt    = sq_r;
    rem_nxt   = rem_r;
    bit_nxt   = bit_r;
    unique case (op)
      tdp_pkg::OP_LOAD: begin
        value_nxt = in_value;
        div_nxt   = WIDTH'(2);
        sq_nxt    = (WIDTH+1)'(4);
      end
      tdp_pkg::OP_DIV_INIT: begin
        rem_nxt = '0;
        bit_nxt = BW'(WIDTH-1);
      end
      tdp_pkg::OP_DIV_STEP: begin
        rem_nxt = trial;
        bit_nxt = bit_r - BW'(1);
      end
      tdp_pkg::OP_NEXT: begin
        div_nxt = div_r + WIDTH'(1);
        sq_nxt  = sq_r + {div_r, 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    div_r   <= div_nxt;
    sq_r    <= sq_nxt;
    rem_r   <= rem_nxt;
    bit_r   <= bit_nxt;
  end

  assign status.lt2    = value_r < WIDTH'(2);
  assign status.sq_gt  = sq_r > {1'b0, value_r};
  assign status.bit_nz = bit_r != '0;
  assign status.rem_z  = rem_r == '0;

endmodule

FILE: rtl/trial_division_prime_test.sv
// Steps: IDLE loads an accepted value; SMALL sends zero and one to EMIT as not prime;
//   for each divisor d from 2 up, BOUND sends the value to EMIT as prime once d*d exceeds
//   it, else DINIT and WIDTH remainder steps divide by d, TREM sends it to EMIT as not
//   prime on a zero remainder and NEXT moves on; at most 254 divisors for WIDTH = 16.
// Occupancy: one item in work at a time; in_ready rises as the result is registered,
//   later while a held result stalls the emit step. Reset (rst_n low,
//   synchronous) returns the step counter to idle and empties the output register.
module trial_division_prime_test #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_value,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_prime
);

  tdp_pkg::step_t   pc_r, pc_nxt;
  tdp_pkg::ctl_t    cw;
  tdp_pkg::status_t status;
  tdp_pkg::op_t     op;
  logic             take;
  logic             out_busy;
  logic             verdict_r;
  logic             out_valid_r;
  logic             out_is_prime_r;

  tdp_rom u_rom (
    .pc (pc_r),
    .cw (cw)
  );

  tdp_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk      (clk),
    .op       (op),
    .in_value (in_value),
    .status   (status)
  );

  assign out_busy = out_valid_r && !out_ready;

  always_comb begin
    unique case (cw.cond)
      tdp_pkg::COND_NEVER:    take = 1'b0;
      tdp_pkg::COND_ALWAYS:   take = 1'b1;
      tdp_pkg::COND_NO_IN:    take = !in_valid;
      tdp_pkg::COND_OUT_BUSY: take = out_busy;
      tdp_pkg::COND_LT2:      take = status.lt2;
      tdp_pkg::COND_SQ_GT:    take = status.sq_gt;
      tdp_pkg::COND_BIT_NZ:   take = status.bit_nz;
      tdp_pkg::COND_REM_Z:    take = status.rem_z;
      default:                take = 1'b0;
    endcase
  end

  assign op     = (cw.op == tdp_pkg::OP_LOAD && !in_valid) ? tdp_pkg::OP_NONE : cw.op;
  assign pc_nxt = take ? cw.target : pc_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= tdp_pkg::STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      if (pc_r == tdp_pkg::STEP_EMIT && !take) begin
        out_valid_r    <= 1'b1;
        out_is_prime_r <= verdict_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cw.set_verdict && take) begin
      verdict_r <= cw.verdict;
    end
  end

  assign in_ready     = pc_r == tdp_pkg::STEP_IDLE;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

FILE: rtl/tdp_checker.sv
module tdp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_is_prime
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_is_prime))
    else $error("result item dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in work");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready && !in_valid |=> in_ready)
    else $error("left idle without an input item");

  a_result_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while still busy");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_is_prime (out_is_prime)
);
